>>> hdl/nsr_pkg.sv
// Package for the NMEA sentence receiver: character codes, state type and checksum compare.
`default_nettype none
package nsr_pkg;
	localparam int NSR_LINE_DEPTH = 64;
	localparam int BYTE_W         = 8;
	localparam int LEN_W          = 6;
	localparam int M_TDATA_W      = 16;
	localparam int MIN_HELD       = 6;

	localparam logic [BYTE_W-1:0] CH_START = 8'h24;
	localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_UPA   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_LOWA  = 8'h61;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_EMRD = 5'b00100,
		S_EMLD = 5'b01000,
		S_EMWT = 5'b10000
	} state_t;

	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib,
			input logic [BYTE_W-1:0] letter_base);
		logic [BYTE_W-1:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = letter_base + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

	function automatic logic sum_matches(input logic [BYTE_W-1:0] sum,
			input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
		logic up;
		logic dn;
		up = (hex_char(sum[7:4], CH_UPA) == hi) && (hex_char(sum[3:0], CH_UPA) == lo);
		dn = (hex_char(sum[7:4], CH_LOWA) == hi) && (hex_char(sum[3:0], CH_LOWA) == lo);
		return up || dn;
	endfunction
endpackage
`default_nettype wire

>>> hdl/nsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hdl/nmea_sentence_receiver.sv
// NMEA 0183 sentence receiver: buffers serial bytes, verifies checksum, streams payload.
// Usage:
//   Slave channel (s_*) takes one received character per beat. Each character is
//   written to a line memory; a line feed closes the line. s_tready is high only
//   while the block waits for a character, so it drops during verify and emit.
//   After a line feed the block reads the line back from the memory one entry
//   per cycle, from the '$' up to the CR in front of the line feed, and checks
//   the '$', '*', CR framing and the XOR checksum against the two hex digits.
//   A verified line streams its payload on the master channel (m_*), one beat
//   per character, tlast on the final one, with the payload length beside it.
//   Each payload beat passes through the single memory read port in turn as
//   address, data and output register and waits while m_tready is low; the
//   output register holds its beat while the receiver stalls.
//   The next character is taken only once the line is emitted or rejected.
//   Reset clears the write position and all control state but m_tlast; the line
//   memory is not cleared and needs no clearing pass.
`default_nettype none
module nmea_sentence_receiver #(
	parameter int LINE_DEPTH = nsr_pkg::NSR_LINE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [nsr_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] rx_byte
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [nsr_pkg::M_TDATA_W-1:0]    m_tdata,  // [7:0] payload_byte, [13:8] payload_length
	output logic                                  m_tlast
);
	import nsr_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int PW = $clog2(LINE_DEPTH + 1);

	state_t            state_q;
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     rd_q;
	logic [PW-1:0]     idx_s1;
	logic              vld_s1;
	logic              ok_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] hi_q;
	logic [BYTE_W-1:0] lo_q;
	logic [BYTE_W-1:0] data_q;
	logic [LEN_W-1:0]  len_q;
	logic              last_q;
	logic              valid_q;

	logic [PW-1:0]     wp_eff;
	logic [PW-1:0]     pos_next;
	logic [PW-1:0]     pos_cnt;
	logic              in_beat;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	assign wp_eff    = (wp_q >= PW'(LINE_DEPTH)) ? '0 : wp_q;
	assign pos_next  = wp_eff + PW'(1);
	assign pos_cnt   = pos_q - PW'(MIN_HELD);
	assign s_tready  = (state_q == S_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign ram_we    = in_beat;
	assign ram_waddr = wp_eff[AW-1:0];
	assign ram_raddr = rd_q[AW-1:0];

	nsr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_tdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q    <= '0;
			pos_q   <= '0;
			rd_q    <= '0;
			idx_s1  <= '0;
			vld_s1  <= 1'b0;
			ok_q    <= 1'b0;
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (s_tdata == CH_LF) begin
							wp_q <= '0;
							if (pos_next > PW'(MIN_HELD)) begin
								pos_q   <= pos_next;
								rd_q    <= '0;
								vld_s1  <= 1'b0;
								ok_q    <= 1'b1;
								sum_q   <= '0;
								state_q <= S_SCAN;
							end
						end else begin
							wp_q <= pos_next;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= (rd_q <= pos_q - PW'(2));
					idx_s1 <= rd_q;
					if (vld_s1) begin
						if (idx_s1 == '0) begin
							ok_q <= ok_q && (ram_rdata == CH_START);
						end
						if (idx_s1 != '0 && idx_s1 <= pos_cnt) begin
							sum_q <= sum_q ^ ram_rdata;
						end
						if (idx_s1 == pos_q - PW'(5)) begin
							ok_q <= ok_q && (ram_rdata == CH_STAR);
						end
						if (idx_s1 == pos_q - PW'(2)) begin
							if (ok_q && ram_rdata == CH_CR && sum_matches(sum_q, hi_q, lo_q)) begin
								rd_q    <= PW'(1);
								state_q <= S_EMRD;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							rd_q <= rd_q + PW'(1);
						end
					end else begin
						rd_q <= rd_q + PW'(1);
					end
				end
				S_EMRD: begin
					state_q <= S_EMLD;
				end
				S_EMLD: begin
					valid_q <= 1'b1;
					state_q <= S_EMWT;
				end
				S_EMWT: begin
					if (m_tready) begin
						valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							rd_q    <= rd_q + PW'(1);
							state_q <= S_EMRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && vld_s1) begin
			if (idx_s1 == pos_q - PW'(4)) begin
				hi_q <= ram_rdata;
			end
			if (idx_s1 == pos_q - PW'(3)) begin
				lo_q <= ram_rdata;
			end
		end
		if (state_q == S_EMLD) begin
			data_q <= ram_rdata;
			last_q <= (rd_q == pos_cnt);
			len_q  <= pos_cnt[LEN_W-1:0];
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(M_TDATA_W - LEN_W - BYTE_W){1'b0}}, len_q, data_q};
endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the NMEA sentence receiver: framed serial traffic against a line predictor.
module tb_top;
	import nsr_pkg::*;

	localparam int DEPTH       = NSR_LINE_DEPTH;
	localparam int CHAR_TARGET = 480;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam int REPORT_MAX  = 10;

	typedef enum int {
		F_UPPER,
		F_LOWER,
		F_MIXED,
		F_BAD_SUM,
		F_NO_START,
		F_NO_CR,
		F_NO_STAR
	} frame_kind_e;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              last;
		logic [LEN_W-1:0]  len;
	} payload_beat_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata  = '0;  // [7:0] rx_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [7:0] payload_byte, [13:8] payload_length
	logic                 m_tlast;

	logic [BYTE_W-1:0] shadow_line [DEPTH];
	logic [6:0]        shadow_pos = '0;
	payload_beat_t     payload_q[$];
	logic [BYTE_W-1:0] char_q[$];

	int chars_sent     = 0;
	int beats_seen     = 0;
	int sentences_seen = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int phase_left     = 0;
	int stall_mode     = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	nmea_sentence_receiver #(
		.LINE_DEPTH(DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] nib, input bit lower);
		if (nib < 4'd10) begin
			return CH_ZERO + BYTE_W'(nib);
		end
		return (lower ? CH_LOWA : CH_UPA) + BYTE_W'(nib - 4'd10);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_char_except(input logic [BYTE_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		do begin
			v = BYTE_W'($urandom_range(0, 255));
		end while (v == a || v == b);
		return v;
	endfunction

	task automatic absorb_char(input logic [BYTE_W-1:0] c);
		int                held;
		int                cnt;
		logic [BYTE_W-1:0] xsum;
		logic              up_ok;
		logic              dn_ok;
		payload_beat_t     bt;
		if (shadow_pos >= DEPTH) begin
			shadow_pos = '0;
		end
		shadow_line[shadow_pos] = c;
		shadow_pos = shadow_pos + 7'd1;
		if (c != CH_LF) begin
			return;
		end
		held = shadow_pos;
		shadow_pos = '0;
		if (held <= MIN_HELD || held > DEPTH) begin
			return;
		end
		if (shadow_line[0] != CH_START || shadow_line[held-2] != CH_CR ||
				shadow_line[held-5] != CH_STAR) begin
			return;
		end
		xsum = '0;
		for (int n = 1; n < held - 5; n++) begin
			xsum ^= shadow_line[n];
		end
		up_ok = hex_ascii(xsum[7:4], 1'b0) == shadow_line[held-4] &&
			hex_ascii(xsum[3:0], 1'b0) == shadow_line[held-3];
		dn_ok = hex_ascii(xsum[7:4], 1'b1) == shadow_line[held-4] &&
			hex_ascii(xsum[3:0], 1'b1) == shadow_line[held-3];
		if (!(up_ok || dn_ok)) begin
			return;
		end
		cnt = held - 6;
		for (int n = 0; n < cnt; n++) begin
			bt.ch   = shadow_line[n+1];
			bt.last = (n == cnt - 1);
			bt.len  = LEN_W'(cnt);
			payload_q.push_back(bt);
		end
	endtask

	task automatic queue_noise(input int n, input bit end_line);
		for (int i = 0; i < n; i++) begin
			char_q.push_back(rand_char_except(CH_LF, CH_LF));
		end
		if (end_line) begin
			char_q.push_back(CH_LF);
		end
	endtask

	task automatic queue_frame(input int plen, input frame_kind_e kind);
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] xsum;
		logic [BYTE_W-1:0] v;
		// hold regenerating until both digits are letters so mixed case must fail
		do begin
			body.delete();
			xsum = '0;
			for (int i = 0; i < plen; i++) begin
				v = rand_char_except(CH_LF, CH_LF);
				body.push_back(v);
				xsum ^= v;
			end
		end while (kind == F_MIXED && plen > 0 && (xsum[7:4] < 4'd10 || xsum[3:0] < 4'd10));
		if (kind == F_BAD_SUM) begin
			xsum ^= BYTE_W'($urandom_range(1, 255));
		end
		char_q.push_back(kind == F_NO_START ? rand_char_except(CH_START, CH_LF) : CH_START);
		foreach (body[i]) begin
			char_q.push_back(body[i]);
		end
		char_q.push_back(kind == F_NO_STAR ? rand_char_except(CH_STAR, CH_LF) : CH_STAR);
		char_q.push_back(hex_ascii(xsum[7:4], kind == F_LOWER));
		char_q.push_back(hex_ascii(xsum[3:0], kind == F_LOWER || kind == F_MIXED));
		char_q.push_back(kind == F_NO_CR ? rand_char_except(CH_CR, CH_LF) : CH_CR);
		char_q.push_back(CH_LF);
	endtask

	task automatic report_mismatch(input string what, input payload_beat_t want);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("mismatch (%s) at %0t: expected ch=%02h len=%0d last=%0b,",
				what, $realtime, want.ch, want.len, want.last);
			$display("    got ch=%02h len=%0d last=%0b",
				m_tdata[7:0], m_tdata[13:8], m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left = $urandom_range(1, 40);
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_char(s_tdata);
				chars_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (char_q.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= char_q.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			phase_left = 0;
			stall_mode = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (m_tlast) begin
					sentences_seen++;
				end
				if (payload_q.size() == 0) begin
					report_mismatch("unexpected beat", '0);
				end else if (m_tdata[7:0] != payload_q[0].ch || m_tdata[13:8] != payload_q[0].len ||
						m_tlast != payload_q[0].last) begin
					report_mismatch("wrong beat", payload_q.pop_front());
				end else begin
					void'(payload_q.pop_front());
				end
			end
			if (phase_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				phase_left = $urandom_range(5, 60);
			end
			phase_left--;
			case (stall_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				default: begin
					m_tready <= ($urandom_range(0, 7) == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("timeout: no beat for %0d cycles, %0d beats still expected",
						idle_cycles, payload_q.size());
					$display("Regression FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		int r;
		queue_frame(1, F_UPPER);
		queue_frame(58, F_UPPER);
		queue_frame(5, F_LOWER);
		queue_frame(4, F_MIXED);
		queue_frame(6, F_BAD_SUM);
		queue_frame(3, F_NO_START);
		queue_frame(3, F_NO_CR);
		queue_frame(3, F_NO_STAR);
		queue_frame(0, F_UPPER);
		char_q.push_back(CH_LF);
		queue_frame(59, F_UPPER);
		queue_noise(DEPTH, 1'b0);
		queue_frame(3, F_UPPER);
		queue_noise(2 * DEPTH, 1'b0);
		queue_frame(2, F_LOWER);
		queue_frame(20, F_UPPER);

		while (char_q.size() < CHAR_TARGET) begin
			r = $urandom_range(0, 19);
			if (r <= 11) begin
				queue_frame($urandom_range(1, 12), $urandom_range(0, 1) ? F_UPPER : F_LOWER);
			end else if (r <= 13) begin
				queue_frame($urandom_range(1, 12), frame_kind_e'($urandom_range(F_MIXED, F_NO_STAR)));
			end else if (r == 14) begin
				queue_noise($urandom_range(0, 8), 1'b1);
			end else if (r == 15) begin
				queue_frame($urandom_range(30, 58), $urandom_range(0, 1) ? F_UPPER : F_LOWER);
			end else if (r == 16) begin
				queue_noise(DEPTH, 1'b0);
				queue_frame($urandom_range(1, 8), F_UPPER);
			end else if (r == 17) begin
				queue_noise($urandom_range(1, 3), 1'b0);
				queue_frame($urandom_range(1, 8), F_UPPER);
			end else begin
				queue_frame($urandom_range(0, 3), $urandom_range(0, 1) ? F_UPPER : F_LOWER);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || s_tvalid || payload_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d serial characters (directed framing cases, random sentences, noise).",
			chars_sent);
		$display("Checked %0d payload beats across %0d verified sentences, %0d mismatches.",
			beats_seen, sentences_seen, mismatches);
		if (mismatches == 0 && payload_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
